@@ rtl/core/set_of_bounded_stacks_defines.svh @@
// assertion macros for the bounded stack set
`ifndef SET_OF_BOUNDED_STACKS_DEFINES_SVH
`define SET_OF_BOUNDED_STACKS_DEFINES_SVH

`ifndef ASSERT_OFF
// implication property checked on every rising clock edge outside reset
`define SOBS_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);
// condition that must never be true outside reset
`define SOBS_NEVER(lbl, clk_sig, rst_sig, cond, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) else $error(msg);
`else
`define SOBS_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define SOBS_NEVER(lbl, clk_sig, rst_sig, cond, msg)
`endif

`endif

@@ rtl/core/sobs_pkg.sv @@
// shared constants and types of the bounded stack set
package sobs_pkg;

    localparam int PLATES_PER_STACK = 10;
    localparam int MAX_STACKS       = 8;
    localparam int STORE_DEPTH      = MAX_STACKS * PLATES_PER_STACK;

    localparam int SLOT_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int LEN_W  = $clog2(MAX_STACKS + 1);
    localparam int FILL_W = $clog2(PLATES_PER_STACK + 1);
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int VALUE_W = 32;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_POP_AT = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] plate_value;
        logic [2:0]         stack_index;
    } cmd_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] popped_value;
        logic [3:0]         stacks_in_use;
    } rsp_t;

    // outcome of one operation as decided by the list controller
    typedef struct packed {
        logic              ok;
        logic              is_pop;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len_after;
    } op_t;

endpackage

@@ rtl/core/sobs_ram.sv @@
// generic single-port ram with registered read
module sobs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/sobs_ctrl.sv @@
// list controller: fill counts, slot order and list length
module sobs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  sobs_pkg::cmd_t cmd,
    output sobs_pkg::op_t  op
);
    import sobs_pkg::*;

    logic [FILL_W-1:0] fill_reg  [MAX_STACKS];
    logic [FILL_W-1:0] fill_next [MAX_STACKS];
    logic [SLOT_W-1:0] order_reg  [MAX_STACKS];
    logic [SLOT_W-1:0] order_next [MAX_STACKS];
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                fill_reg[i]  <= '0;
                order_reg[i] <= SLOT_W'(i);
            end
            len_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            order_reg <= order_next;
            len_reg   <= len_next;
        end
    end

    always_comb
    begin
        logic              found;
        logic [SLOT_W-1:0] fslot;
        logic [SLOT_W-1:0] nslot;
        logic              is_pop_last;
        logic              tgt_ok;
        logic [SLOT_W-1:0] p;
        logic [SLOT_W-1:0] rslot;
        logic              empty;
        logic [SLOT_W-1:0] shifted [MAX_STACKS];
        logic [SLOT_W-1:0] ord2 [MAX_STACKS];
        logic [LEN_W-1:0]  len_rm;
        logic              take_ok;
        logic [SLOT_W-1:0] p2;
        logic [SLOT_W-1:0] tslot;
        logic [FILL_W-1:0] tfill;

        fill_next  = fill_reg;
        order_next = order_reg;
        len_next   = len_reg;
        op         = '0;

        // first-fit search for push
        found = 1'b0;
        fslot = '0;
        for (int i = 0; i < MAX_STACKS; i++)
        begin
            if (!found && (LEN_W'(i) < len_reg)
                && (fill_reg[order_reg[i]] < FILL_W'(PLATES_PER_STACK)))
            begin
                found = 1'b1;
                fslot = order_reg[i];
            end
        end
        nslot = order_reg[len_reg[SLOT_W-1:0]];

        // target position of a pop or pop-at
        is_pop_last = (cmd.opcode == OP_POP);
        tgt_ok = is_pop_last ? (len_reg != '0) : (LEN_W'(cmd.stack_index) < len_reg);
        p      = is_pop_last ? SLOT_W'(len_reg - LEN_W'(1)) : SLOT_W'(cmd.stack_index);
        rslot  = order_reg[p];
        empty  = (fill_reg[rslot] == '0);

        // removal of position p moves its slot to the end of the list
        for (int i = 0; i < MAX_STACKS; i++)
        begin
            if ((SLOT_W'(i) >= p) && (LEN_W'(i) + LEN_W'(1) < len_reg))
            begin
                shifted[i] = order_reg[(i + 1) % MAX_STACKS];
            end
            else if ((SLOT_W'(i) >= p) && (LEN_W'(i) + LEN_W'(1) == len_reg))
            begin
                shifted[i] = rslot;
            end
            else
            begin
                shifted[i] = order_reg[i];
            end
        end
        for (int i = 0; i < MAX_STACKS; i++)
        begin
            ord2[i] = empty ? shifted[i] : order_reg[i];
        end
        len_rm = empty ? len_reg - LEN_W'(1) : len_reg;

        take_ok = is_pop_last ? (len_rm != '0) : (LEN_W'(p) < len_rm);
        p2      = is_pop_last ? SLOT_W'(len_rm - LEN_W'(1)) : p;
        tslot   = ord2[p2];
        tfill   = fill_reg[tslot];

        if (accept)
        begin
            case (cmd.opcode)
                OP_PUSH:
                begin
                    if (found)
                    begin
                        op.ok   = 1'b1;
                        op.we   = 1'b1;
                        op.addr = ADDR_W'(fslot) * ADDR_W'(PLATES_PER_STACK)
                                  + ADDR_W'(fill_reg[fslot]);
                        fill_next[fslot] = fill_reg[fslot] + FILL_W'(1);
                    end
                    else if (len_reg < LEN_W'(MAX_STACKS))
                    begin
                        op.ok   = 1'b1;
                        op.we   = 1'b1;
                        op.addr = ADDR_W'(nslot) * ADDR_W'(PLATES_PER_STACK);
                        fill_next[nslot] = FILL_W'(1);
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                OP_POP, OP_POP_AT:
                begin
                    if (tgt_ok)
                    begin
                        order_next = ord2;
                        len_next   = len_rm;
                        if (take_ok && (tfill != '0))
                        begin
                            op.ok     = 1'b1;
                            op.is_pop = 1'b1;
                            op.addr   = ADDR_W'(tslot) * ADDR_W'(PLATES_PER_STACK)
                                        + ADDR_W'(tfill - FILL_W'(1));
                            fill_next[tslot] = tfill - FILL_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        op.len_after = len_next;
    end

endmodule

@@ rtl/core/set_of_bounded_stacks.sv @@
// top level of the bounded stack set
// usage
//   a command transfer happens at a rising edge where start is high and busy is low;
//   cmd carries opcode (push, pop from the last sub-stack, pop at an index),
//   plate_value for push and stack_index for pop-at
//   the result comes back in the cycle after the transfer: done is high
//   for that one cycle and rsp holds ok, popped_value and stacks_in_use
//   busy is high during the result cycle, so no new command is taken while
//   a result is shown; this is set by the registered read of the
//   plate ram that a pop needs before its value can be shown
//   all list bookkeeping (fill counts, slot order, list length) is decided in
//   the cycle of the transfer and the plate ram is written or read at that edge
//   the receiver cannot stall; done is a strobe and must be taken when shown
//   reset clears the list: no sub-stacks, every fill count zero, slot order
//   back to identity; the plate ram itself is not cleared, its entries are
//   only read after they were written
module set_of_bounded_stacks (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  sobs_pkg::cmd_t cmd,
    output logic           done,
    output sobs_pkg::rsp_t rsp
);
    import sobs_pkg::*;

    `include "set_of_bounded_stacks_defines.svh"

    logic              accept;
    op_t               op;
    logic [VALUE_W-1:0] ram_rdata;

    // response stage
    logic              done_reg;
    logic              ok_reg;
    logic              pop_reg;
    logic [LEN_W-1:0]  len_reg;

    assign accept = start && !busy;

    sobs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd),
        .op     (op)
    );

    // plate storage, one row of entries per physical sub-stack slot
    sobs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_plate_ram (
        .clk   (clk),
        .we    (op.we),
        .addr  (op.addr),
        .wdata (cmd.plate_value),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    // result payload, captured with the transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg  <= op.ok;
            pop_reg <= op.is_pop;
            len_reg <= op.len_after;
        end
    end

    assign busy = done_reg;
    assign done = done_reg;

    // popped value comes straight from the ram read register
    assign rsp.ok            = ok_reg;
    assign rsp.popped_value  = pop_reg ? ram_rdata : '0;
    assign rsp.stacks_in_use = 4'(len_reg);

    `SOBS_ASSERT(a_done_follows_transfer, clk, rst_n, accept |=> done, "no result after transfer")
    `SOBS_NEVER(a_len_bound, clk, rst_n, done && (rsp.stacks_in_use > 4'(MAX_STACKS)), "list too long")
    `SOBS_NEVER(a_fail_zero, clk, rst_n, done && !rsp.ok && (rsp.popped_value != '0), "failed op returned a value")
    `SOBS_ASSERT(a_push_nonempty, clk, rst_n, (done && rsp.ok && $past(cmd.opcode == OP_PUSH)) |-> (rsp.stacks_in_use != '0), "push left list empty")

endmodule
